// ===== sv/stepper_step_rate_generator_assert.svh =====
// ----------------------------------------------------------------------------
// stepper step rate generator assertion macros
// shared property templates for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef STEPPER_STEP_RATE_GENERATOR_ASSERT_SVH
`define STEPPER_STEP_RATE_GENERATOR_ASSERT_SVH

// same-cycle implication, reset masked
`define SSRG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssrg assertion failed");

// next-cycle implication, reset masked
`define SSRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssrg assertion failed");

`endif

// ===== sv/ssrg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssrg_pkg
// widths, codes and defaults of the stepper step rate generator
// ----------------------------------------------------------------------------
`default_nettype none

package ssrg_pkg;

  // field widths
  localparam int FUNC_W      = 2;
  localparam int SPEED_W     = 16;
  localparam int FULL_RATE_W = 17;
  localparam int PERIOD_W    = 16;
  localparam int CMP_W       = 7;
  localparam int POS_OUT_W   = 32;
  localparam int CFG_IDX_W   = 1;

  // default parameter values
  localparam int TICKS_PER_SECOND_DEF = 1000000;
  localparam int MIN_STEP_RATE_DEF    = 16;
  localparam int POSITION_BITS_DEF    = 32;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_ENABLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SPEED  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_POL   = 1'b1;

  // timer constants
  localparam logic [PERIOD_W-1:0]    PERIOD_RESET  = 16'd65000;
  localparam logic [PERIOD_W-1:0]    RELOAD_IDLE   = 16'd1000;
  localparam logic [PERIOD_W-1:0]    PERIOD_MAX    = 16'hFFFF;
  localparam logic [CMP_W-1:0]       COMPARE_PULSE = 7'd100;
  localparam logic [CMP_W-1:0]       COMPARE_OFF   = 7'd0;
  localparam logic [FULL_RATE_W-1:0] FULL_RATE_RST = 17'd1000;

  // percent in q8.8 scaled to full speed: 100 * 256 = 25600
  localparam int PCT_FRAC_BITS = 8;
  localparam int PCT_FULL      = 100;

endpackage

`default_nettype wire

// ===== sv/stepper_step_rate_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_step_rate_generator
// enable, direction and step state of a timer-clocked stepper driver, with a
// bit-serial speed-to-period path (shift-add multiply, two restoring divides)
// ----------------------------------------------------------------------------
//
//  channel | ports                                          | role
//  --------+------------------------------------------------+------------------
//  in      | in_valid/in_ready, func, enable_value, speed  | command or tick
//  out     | out_valid/out_ready, eight state fields       | state after item
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data      | register write
//
//  enable, tick and ignored commands: the accepted item goes to the emit step,
//  which loads the output register; no new item is taken until it is done.
//  a nonzero speed while enabled takes SPEED_W multiply steps, then two
//  restoring divides of NUM_W steps each with a load step between them,
//  then a finish and an emit step.
//  rst_n is synchronous active low; cfg_ready is always high.
//  the result sits in an output register, so the next beat is taken while it
//  waits; a stalled out channel holds only the emit step of the next item.
//
`default_nettype none
`include "stepper_step_rate_generator_assert.svh"

module stepper_step_rate_generator #(
  parameter int TICKS_PER_SECOND = ssrg_pkg::TICKS_PER_SECOND_DEF,
  parameter int MIN_STEP_RATE    = ssrg_pkg::MIN_STEP_RATE_DEF,
  parameter int POSITION_BITS    = ssrg_pkg::POSITION_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // command channel
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [ssrg_pkg::FUNC_W-1:0]          in_func,
  input  wire                                  in_enable_value,
  input  wire  signed [ssrg_pkg::SPEED_W-1:0]  in_speed_percent,
  // result channel
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 out_step_issued,
  output logic signed [ssrg_pkg::POS_OUT_W-1:0] out_position,
  output logic [ssrg_pkg::PERIOD_W-1:0]        out_reload_value,
  output logic [ssrg_pkg::CMP_W-1:0]           out_compare_value,
  output logic [ssrg_pkg::PERIOD_W-1:0]        out_pending_period,
  output logic                                 out_dir_pin,
  output logic                                 out_enable_pin,
  output logic                                 out_running,
  // configuration channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [ssrg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ssrg_pkg::FULL_RATE_W-1:0]     cfg_data
);

  // derived widths
  localparam int SPEED_W   = ssrg_pkg::SPEED_W;
  localparam int MS_W      = ssrg_pkg::FULL_RATE_W;
  localparam int PROD_W    = MS_W + SPEED_W;
  localparam int SCALED_W  = PROD_W - ssrg_pkg::PCT_FRAC_BITS;
  localparam int TPS_W     = $clog2(TICKS_PER_SECOND + 1);
  localparam int NUM_W     = (SCALED_W > TPS_W) ? SCALED_W : TPS_W;
  localparam int MIN_W     = $clog2(MIN_STEP_RATE + 1);
  localparam int DEN_W     = (MS_W > MIN_W) ? MS_W : MIN_W;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int PW        = ssrg_pkg::PERIOD_W;
  localparam int OW        = ssrg_pkg::POS_OUT_W;

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV1  = 3'd2;
  localparam logic [2:0] ST_LOAD2 = 3'd3;
  localparam logic [2:0] ST_DIV2  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  // control and state registers
  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [MS_W-1:0]          full_rate_r, full_rate_nxt;
  logic                     dir_pol_r, dir_pol_nxt;
  logic                     enabled_r, enabled_nxt;
  logic                     stepping_r, stepping_nxt;
  logic                     dir_level_r, dir_level_nxt;
  logic [POSITION_BITS-1:0] step_count_r, step_count_nxt;
  logic [PW-1:0]            next_period_r, next_period_nxt;
  logic [PW-1:0]            reload_r, reload_nxt;
  logic [ssrg_pkg::CMP_W-1:0] compare_r, compare_nxt;
  logic                     issued_r, issued_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // datapath registers
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [NUM_W-1:0]         num_r, num_nxt;
  logic [DEN_W-1:0]         rem_r, rem_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic                     neg_r, neg_nxt;

  // output payload registers
  logic                     out_issued_r;
  logic [OW-1:0]            out_pos_r;
  logic [PW-1:0]            out_reload_r;
  logic [ssrg_pkg::CMP_W-1:0] out_compare_r;
  logic [PW-1:0]            out_pending_r;
  logic                     out_dir_r;
  logic                     out_en_pin_r;
  logic                     out_running_r;

  logic                     in_beat;
  logic                     out_free;
  logic                     emit_load;
  logic [SPEED_W-1:0]       raw_mag;
  logic [MS_W:0]            mul_sum;
  logic [DEN_W:0]           div_shift;
  logic [DEN_W+1:0]         div_diff;
  logic                     div_ge;
  logic [NUM_W-1:0]         m_hi;
  logic [NUM_W-1:0]         m_clamped;
  logic [PW-1:0]            period_sat;
  logic [OW-1:0]            pos_ext;
  logic                     cmp_legal;
  logic                     step_legal;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign emit_load = (state_r == ST_EMIT) && out_free;

  // magnitude of the q8.8 percent
  assign raw_mag = in_speed_percent[SPEED_W-1] ? (~in_speed_percent + 1'b1)
                                               : in_speed_percent;

  // shift-add multiply step: low bit of prod_r is the current multiplier bit
  assign mul_sum = {1'b0, prod_r[PROD_W-1:SPEED_W]}
                 + (prod_r[0] ? {1'b0, full_rate_r} : {(MS_W+1){1'b0}});

  // restoring divide step, one quotient bit per cycle
  assign div_shift = {rem_r, num_r[NUM_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, den_r};
  assign div_ge    = !div_diff[DEN_W+1];

  // clamp rate to the full rate, then to the minimum rate
  assign m_hi      = (num_r > NUM_W'(full_rate_r)) ? NUM_W'(full_rate_r) : num_r;
  assign m_clamped = (m_hi < NUM_W'(MIN_STEP_RATE)) ? NUM_W'(MIN_STEP_RATE) : m_hi;

  // period saturates to the timer width
  assign period_sat = (num_r > NUM_W'(ssrg_pkg::PERIOD_MAX)) ? ssrg_pkg::PERIOD_MAX
                                                             : num_r[PW-1:0];

  // position counter to the 32-bit port
  generate
    if (POSITION_BITS >= OW) begin : g_pos_trunc
      assign pos_ext = step_count_r[OW-1:0];
    end else begin : g_pos_sext
      assign pos_ext = {{(OW-POSITION_BITS){step_count_r[POSITION_BITS-1]}},
                        step_count_r};
    end
  endgenerate

  // sequencer and state update
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    full_rate_nxt   = full_rate_r;
    dir_pol_nxt     = dir_pol_r;
    enabled_nxt     = enabled_r;
    stepping_nxt    = stepping_r;
    dir_level_nxt   = dir_level_r;
    step_count_nxt  = step_count_r;
    next_period_nxt = next_period_r;
    reload_nxt      = reload_r;
    compare_nxt     = compare_r;
    issued_nxt      = issued_r;
    prod_nxt        = prod_r;
    num_nxt         = num_r;
    rem_nxt         = rem_r;
    den_nxt         = den_r;
    neg_nxt         = neg_r;

    // register writes
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ssrg_pkg::CFG_FULL_RATE: full_rate_nxt = cfg_data;
        ssrg_pkg::CFG_DIR_POL:   dir_pol_nxt   = cfg_data[0];
        default:                 full_rate_nxt = full_rate_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          issued_nxt = 1'b0;
          state_nxt  = ST_EMIT;
          case (in_func)
            ssrg_pkg::FUNC_ENABLE: begin
              enabled_nxt = in_enable_value;
              if (!in_enable_value) begin
                stepping_nxt = 1'b0;
              end
            end
            ssrg_pkg::FUNC_SPEED: begin
              if (enabled_r) begin
                if (in_speed_percent == '0) begin
                  stepping_nxt = 1'b0;
                  compare_nxt  = ssrg_pkg::COMPARE_OFF;
                  reload_nxt   = ssrg_pkg::RELOAD_IDLE;
                end else begin
                  neg_nxt   = in_speed_percent[SPEED_W-1];
                  prod_nxt  = {{MS_W{1'b0}}, raw_mag};
                  cnt_nxt   = CNT_W'(SPEED_W - 1);
                  state_nxt = ST_MUL;
                end
              end
            end
            ssrg_pkg::FUNC_TICK: begin
              if (stepping_r) begin
                step_count_nxt = dir_level_r ? step_count_r + 1'b1
                                             : step_count_r - 1'b1;
                reload_nxt     = next_period_r;
                compare_nxt    = ssrg_pkg::COMPARE_PULSE;
                issued_nxt     = 1'b1;
              end
            end
            default: issued_nxt = 1'b0;
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt = {mul_sum, prod_r[SPEED_W-1:1]};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DIV1;
          num_nxt   = NUM_W'(prod_nxt[PROD_W-1:ssrg_pkg::PCT_FRAC_BITS]);
          rem_nxt   = '0;
          den_nxt   = DEN_W'(ssrg_pkg::PCT_FULL);
          cnt_nxt   = CNT_W'(NUM_W - 1);
        end
      end
      ST_DIV1, ST_DIV2: begin
        rem_nxt = div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = (state_r == ST_DIV1) ? ST_LOAD2 : ST_FIN;
        end
      end
      ST_LOAD2: begin
        den_nxt   = m_clamped[DEN_W-1:0];
        num_nxt   = NUM_W'(TICKS_PER_SECOND);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(NUM_W - 1);
        state_nxt = ST_DIV2;
      end
      ST_FIN: begin
        next_period_nxt = period_sat;
        stepping_nxt    = 1'b1;
        dir_level_nxt   = !neg_r ^ dir_pol_r;
        state_nxt       = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // output register handshake
    out_valid_nxt = out_valid_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      cnt_r         <= '0;
      full_rate_r   <= ssrg_pkg::FULL_RATE_RST;
      dir_pol_r     <= 1'b0;
      enabled_r     <= 1'b0;
      stepping_r    <= 1'b0;
      dir_level_r   <= 1'b1;
      step_count_r  <= '0;
      next_period_r <= ssrg_pkg::PERIOD_RESET;
      reload_r      <= ssrg_pkg::RELOAD_IDLE;
      compare_r     <= ssrg_pkg::COMPARE_OFF;
      issued_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      full_rate_r   <= full_rate_nxt;
      dir_pol_r     <= dir_pol_nxt;
      enabled_r     <= enabled_nxt;
      stepping_r    <= stepping_nxt;
      dir_level_r   <= dir_level_nxt;
      step_count_r  <= step_count_nxt;
      next_period_r <= next_period_nxt;
      reload_r      <= reload_nxt;
      compare_r     <= compare_nxt;
      issued_r      <= issued_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // serial datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_issued_r  <= issued_r;
      out_pos_r     <= pos_ext;
      out_reload_r  <= reload_r;
      out_compare_r <= compare_r;
      out_pending_r <= next_period_r;
      out_dir_r     <= dir_level_r;
      out_en_pin_r  <= !enabled_r;
      out_running_r <= stepping_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_step_issued    = out_issued_r;
  assign out_position       = out_pos_r;
  assign out_reload_value   = out_reload_r;
  assign out_compare_value  = out_compare_r;
  assign out_pending_period = out_pending_r;
  assign out_dir_pin        = out_dir_r;
  assign out_enable_pin     = out_en_pin_r;
  assign out_running        = out_running_r;

  // terms for the checks
  assign cmp_legal  = (out_compare_value == ssrg_pkg::COMPARE_OFF)
                   || (out_compare_value == ssrg_pkg::COMPARE_PULSE);
  assign step_legal = out_running && (out_compare_value == ssrg_pkg::COMPARE_PULSE);

  // checks
  `SSRG_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)
  `SSRG_ASSERT_IMPL(a_cmp_codes, clk, rst_n, out_valid, cmp_legal)
  `SSRG_ASSERT_IMPL(a_step_running, clk, rst_n, out_valid && out_step_issued, step_legal)
  `SSRG_ASSERT_IMPL(a_rate_nonzero, clk, rst_n, state_r == ST_DIV2, den_r != '0)

endmodule

`default_nettype wire
